// ===== src/dtm_pkg.sv =====
// Shared constants, codes and types for the DFA token matcher.
// No dependencies; every other file in src refers to it by scoped names.
`timescale 1ns / 1ps

package dtm_pkg;

  localparam int STATE_W        = 6;    // state fields on the ports
  localparam int CHAR_W         = 8;
  localparam int CLASS_ENTRIES  = 256;  // one class map entry per byte value
  localparam int MASK_IN_W      = 32;   // mask fields on the ports
  localparam int MAX_CLASS_BITS = 64;
  localparam int CFG_AW         = 3;
  localparam int CFG_DW         = 32;

  localparam int DEF_NUM_STATES      = 64;
  localparam int DEF_EDGES_PER_STATE = 8;
  localparam int DEF_CLASS_BITS      = 32;

  localparam logic [CFG_AW-1:0] REG_START_ADDR = 3'd0;
  localparam logic [CFG_AW-1:0] REG_END_ADDR   = 3'd4;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_EDGE_WR  = 2'd1,
    KIND_CLASS_WR = 2'd2,
    KIND_EMPTY    = 2'd3
  } item_kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STEP
  } seq_state_t;

  // Outcome of the edge search for one character.
  typedef struct packed {
    logic               hit;
    logic [STATE_W-1:0] target;
  } match_res_t;

endpackage

// ===== src/dfa_token_matcher.sv =====
// DFA token matcher. Characters of a token arrive one per request (kind 0,
// last marks the final one); each byte is mapped through the class map to a
// class mask, and the lowest valid edge slot of the current state whose mask
// shares a bit with it gives the next state. A token with no matching slot is
// rejected and its remaining characters are skipped. The last character, or an
// empty-token request (kind 3), produces one result and returns to start_state.
// Edge slot writes (kind 1) and class map writes (kind 2) load the tables and
// produce nothing. For a character the class map and edge row are read
// together in the accept cycle and the search and state update run in the
// next; table writes and empty tokens are handled in the accept cycle.
// The loop that sets this pace is state register -> edge row read -> slot
// search -> state register. After reset a clearing pass zeroes both
// tables; in_stall stays high meanwhile, register writes are still taken.
// Any request is held off during a character step, a result-producing one
// also while a previous result is still waiting stalled in the output register.
// Depends on dtm_pkg, dtm_class_mem, dtm_edge_mem and dtm_match.
`timescale 1ns / 1ps

module dfa_token_matcher #(
  parameter int NUM_STATES      = dtm_pkg::DEF_NUM_STATES,
  parameter int EDGES_PER_STATE = dtm_pkg::DEF_EDGES_PER_STATE,
  parameter int CLASS_BITS      = dtm_pkg::DEF_CLASS_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_kind,
  input  logic [dtm_pkg::CHAR_W-1:0]        in_ch,
  input  logic                              in_last,
  input  logic [dtm_pkg::STATE_W-1:0]       in_state_index,
  input  logic [2:0]                        in_slot_index,
  input  logic [dtm_pkg::STATE_W-1:0]       in_target_state,
  input  logic [dtm_pkg::MASK_IN_W-1:0]     in_edge_mask,
  input  logic                              in_slot_valid,
  input  logic [dtm_pkg::MASK_IN_W-1:0]     in_class_mask,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_accepted,
  output logic                              out_at_end_state,
  output logic [dtm_pkg::STATE_W-1:0]       out_final_state,
  // register port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [dtm_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [dtm_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [dtm_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);

  localparam int SW     = $clog2(NUM_STATES);
  localparam int EXT_W  = (SW > dtm_pkg::STATE_W) ? SW : dtm_pkg::STATE_W;
  localparam int SLOTW  = 1 + dtm_pkg::STATE_W + CLASS_BITS;
  localparam int CLR_N  = (NUM_STATES > dtm_pkg::CLASS_ENTRIES) ?
                          NUM_STATES : dtm_pkg::CLASS_ENTRIES;
  localparam int CW     = $clog2(CLR_N);
  localparam int MAX_CB_W = dtm_pkg::MAX_CLASS_BITS;

  // ---------------------------------------------------------------- registers
  logic [dtm_pkg::STATE_W-1:0] start_state_r;
  logic [dtm_pkg::STATE_W-1:0] end_state_r;
  logic [dtm_pkg::STATE_W-1:0] cur_state_r, cur_state_nxt;
  logic                        rejected_r, rejected_nxt;
  dtm_pkg::seq_state_t         seq_r, seq_nxt;
  logic [CW-1:0]               clr_cnt_r;
  logic                        last_r;      // step payload, no reset
  logic                        in_range_r;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_accepted_r, out_accepted_nxt;
  logic                        out_at_end_r, out_at_end_nxt;
  logic [dtm_pkg::STATE_W-1:0] out_final_r, out_final_nxt;

  // ---------------------------------------------------------------- decode
  logic in_take, gives_result, is_char, is_edge_wr, is_class_wr, is_empty;
  logic cfg_wr, cfg_wr_start, cfg_wr_end;
  logic clearing;

  assign is_char     = (in_kind == dtm_pkg::KIND_CHAR);
  assign is_edge_wr  = (in_kind == dtm_pkg::KIND_EDGE_WR);
  assign is_class_wr = (in_kind == dtm_pkg::KIND_CLASS_WR);
  assign is_empty    = (in_kind == dtm_pkg::KIND_EMPTY);
  assign gives_result = is_empty || (is_char && in_last);

  assign clearing = (seq_r == dtm_pkg::ST_CLEAR);
  // one request per idle cycle; a result request also needs room at the output
  assign in_stall = (seq_r != dtm_pkg::ST_IDLE) ||
                    (out_valid_r && out_stall && gives_result);
  assign in_take  = in_valid && !in_stall;

  assign cfg_pready   = 1'b1;
  assign cfg_wr       = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_wr_start = cfg_wr && (cfg_paddr == dtm_pkg::REG_START_ADDR);
  assign cfg_wr_end   = cfg_wr && (cfg_paddr == dtm_pkg::REG_END_ADDR);

  always_comb begin
    case (cfg_paddr)
      dtm_pkg::REG_START_ADDR: cfg_prdata = dtm_pkg::CFG_DW'(start_state_r);
      dtm_pkg::REG_END_ADDR:   cfg_prdata = dtm_pkg::CFG_DW'(end_state_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_state_r <= '0;
      end_state_r   <= '0;
    end else begin
      if (cfg_wr_start) start_state_r <= cfg_pwdata[dtm_pkg::STATE_W-1:0];
      if (cfg_wr_end)   end_state_r   <= cfg_pwdata[dtm_pkg::STATE_W-1:0];
    end
  end

  // ---------------------------------------------------------------- tables
  logic [EXT_W-1:0]                   cur_ext, wr_state_ext;
  logic [MAX_CB_W-1:0]                edge_mask_ext, class_mask_ext;
  logic [EDGES_PER_STATE-1:0]         slot_sel;
  logic                               edge_wr_ok;
  logic                               edge_wr_en, class_wr_en;
  logic [SW-1:0]                      edge_wr_row;
  logic [EDGES_PER_STATE-1:0]         edge_wr_slot_en;
  logic [SLOTW-1:0]                   edge_wr_data;
  logic [dtm_pkg::CHAR_W-1:0]         class_wr_addr;
  logic [CLASS_BITS-1:0]              class_wr_data;
  logic [EDGES_PER_STATE-1:0][SLOTW-1:0] edge_row;
  logic [CLASS_BITS-1:0]              class_rd;
  logic                               clr_edge, clr_class;

  assign cur_ext        = EXT_W'(cur_state_r);
  assign wr_state_ext   = EXT_W'(in_state_index);
  assign edge_mask_ext  = MAX_CB_W'(in_edge_mask);
  assign class_mask_ext = MAX_CB_W'(in_class_mask);

  always_comb begin
    for (int s = 0; s < EDGES_PER_STATE; s++) begin
      slot_sel[s] = (32'(in_slot_index) == s);
    end
  end

  // out of range writes are dropped
  assign edge_wr_ok = (32'(in_state_index) < NUM_STATES) &&
                      (32'(in_slot_index) < EDGES_PER_STATE);

  assign clr_edge  = clearing && (32'(clr_cnt_r) < NUM_STATES);
  assign clr_class = clearing && (32'(clr_cnt_r) < dtm_pkg::CLASS_ENTRIES);

  always_comb begin
    if (clearing) begin
      edge_wr_en      = clr_edge;
      edge_wr_row     = clr_cnt_r[SW-1:0];
      edge_wr_slot_en = '1;
      edge_wr_data    = '0;
      class_wr_en     = clr_class;
      class_wr_addr   = clr_cnt_r[dtm_pkg::CHAR_W-1:0];
      class_wr_data   = '0;
    end else begin
      edge_wr_en      = in_take && is_edge_wr && edge_wr_ok;
      edge_wr_row     = wr_state_ext[SW-1:0];
      edge_wr_slot_en = slot_sel;
      edge_wr_data    = {in_slot_valid, in_target_state, edge_mask_ext[CLASS_BITS-1:0]};
      class_wr_en     = in_take && is_class_wr;
      class_wr_addr   = in_ch;
      class_wr_data   = class_mask_ext[CLASS_BITS-1:0];
    end
  end

  dtm_class_mem #(
    .CLASS_BITS (CLASS_BITS)
  ) u_class_mem (
    .clk     (clk),
    .wr_en   (class_wr_en),
    .wr_addr (class_wr_addr),
    .wr_data (class_wr_data),
    .rd_en   (in_take && is_char),
    .rd_addr (in_ch),
    .rd_data (class_rd)
  );

  dtm_edge_mem #(
    .NUM_STATES      (NUM_STATES),
    .EDGES_PER_STATE (EDGES_PER_STATE),
    .CLASS_BITS      (CLASS_BITS)
  ) u_edge_mem (
    .clk        (clk),
    .wr_en      (edge_wr_en),
    .wr_row     (edge_wr_row),
    .wr_slot_en (edge_wr_slot_en),
    .wr_data    (edge_wr_data),
    .rd_en      (in_take && is_char),
    .rd_row     (cur_ext[SW-1:0]),
    .rd_data    (edge_row)
  );

  dtm_pkg::match_res_t match;

  dtm_match #(
    .EDGES_PER_STATE (EDGES_PER_STATE),
    .CLASS_BITS      (CLASS_BITS)
  ) u_match (
    .row      (edge_row),
    .cls      (class_rd),
    .in_range (in_range_r),
    .res      (match)
  );

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r     <= dtm_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      seq_r <= seq_nxt;
      if (clearing) clr_cnt_r <= clr_cnt_r + CW'(1);
    end
  end

  always_comb begin
    seq_nxt = seq_r;
    case (seq_r)
      dtm_pkg::ST_CLEAR: begin
        if (clr_cnt_r == CW'(CLR_N - 1)) seq_nxt = dtm_pkg::ST_IDLE;
      end
      dtm_pkg::ST_IDLE: begin
        if (in_take && is_char) seq_nxt = dtm_pkg::ST_STEP;
      end
      dtm_pkg::ST_STEP: begin
        seq_nxt = dtm_pkg::ST_IDLE;
      end
      default: begin
        seq_nxt = dtm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_take && is_char) begin
      last_r     <= in_last;
      in_range_r <= (32'(cur_state_r) < NUM_STATES);
    end
  end

  // ---------------------------------------------------------------- token state
  logic                        step_rej;
  logic [dtm_pkg::STATE_W-1:0] step_state;

  // a rejected token keeps its stuck state; a miss marks rejection
  assign step_rej   = rejected_r || !match.hit;
  assign step_state = (!rejected_r && match.hit) ? match.target : cur_state_r;

  always_comb begin
    cur_state_nxt    = cur_state_r;
    rejected_nxt     = rejected_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_accepted_nxt = out_accepted_r;
    out_at_end_nxt   = out_at_end_r;
    out_final_nxt    = out_final_r;

    if (seq_r == dtm_pkg::ST_STEP) begin
      if (last_r) begin
        out_valid_nxt    = 1'b1;
        out_accepted_nxt = !step_rej;
        out_at_end_nxt   = !step_rej && (step_state == end_state_r);
        out_final_nxt    = step_state;
        cur_state_nxt    = start_state_r;
        rejected_nxt     = 1'b0;
      end else begin
        cur_state_nxt    = step_state;
        rejected_nxt     = step_rej;
      end
    end else if (in_take && is_empty) begin
      out_valid_nxt    = 1'b1;
      out_accepted_nxt = 1'b0;
      out_at_end_nxt   = 1'b0;
      out_final_nxt    = start_state_r;
      cur_state_nxt    = start_state_r;
      rejected_nxt     = 1'b0;
    end

    // start_state write aborts any token
    if (cfg_wr_start) begin
      cur_state_nxt = cfg_pwdata[dtm_pkg::STATE_W-1:0];
      rejected_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_state_r <= '0;
      rejected_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_state_r <= cur_state_nxt;
      rejected_r  <= rejected_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_accepted_r <= out_accepted_nxt;
    out_at_end_r   <= out_at_end_nxt;
    out_final_r    <= out_final_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_accepted_r;
  assign out_at_end_state = out_at_end_r;
  assign out_final_state  = out_final_r;

  // ---------------------------------------------------------------- checks
  // a step that closes a token must find the output register free
  a_step_room: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == dtm_pkg::ST_STEP && last_r) |-> (!out_valid_r || !out_stall))
    else $error("token result would overwrite a pending result");

  // the search and update state is always followed by idle
  a_step_len: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == dtm_pkg::ST_STEP) |=> (seq_r == dtm_pkg::ST_IDLE))
    else $error("step state held longer than one cycle");

  // the clearing pass runs once after reset
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r != dtm_pkg::ST_CLEAR) |=> (seq_r != dtm_pkg::ST_CLEAR))
    else $error("clearing pass restarted");

  // an empty token always reports a rejection
  a_empty_rej: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && is_empty) |=> (out_valid_r && !out_accepted_r && !out_at_end_r))
    else $error("empty token not reported as rejected");

endmodule

// ===== src/dtm_class_mem.sv =====
// Class map: one class mask per byte value, synchronous read, one write port.
// Uses dtm_pkg for the entry count and byte width.
`timescale 1ns / 1ps

module dtm_class_mem #(
  parameter int CLASS_BITS = dtm_pkg::DEF_CLASS_BITS
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [dtm_pkg::CHAR_W-1:0]  wr_addr,
  input  logic [CLASS_BITS-1:0]       wr_data,
  input  logic                        rd_en,
  input  logic [dtm_pkg::CHAR_W-1:0]  rd_addr,
  output logic [CLASS_BITS-1:0]       rd_data
);

  logic [CLASS_BITS-1:0] class_mem_r [dtm_pkg::CLASS_ENTRIES];
  logic [CLASS_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      class_mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= class_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/dtm_edge_mem.sv =====
// Edge table: one row per state holding all edge slots, per-slot write enables,
// whole-row synchronous read. Uses dtm_pkg for the state field width.
`timescale 1ns / 1ps

module dtm_edge_mem #(
  parameter int NUM_STATES      = dtm_pkg::DEF_NUM_STATES,
  parameter int EDGES_PER_STATE = dtm_pkg::DEF_EDGES_PER_STATE,
  parameter int CLASS_BITS      = dtm_pkg::DEF_CLASS_BITS,
  localparam int SW    = $clog2(NUM_STATES),
  localparam int SLOTW = 1 + dtm_pkg::STATE_W + CLASS_BITS
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [SW-1:0]                          wr_row,
  input  logic [EDGES_PER_STATE-1:0]             wr_slot_en,
  input  logic [SLOTW-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [SW-1:0]                          rd_row,
  output logic [EDGES_PER_STATE-1:0][SLOTW-1:0]  rd_data
);

  logic [EDGES_PER_STATE-1:0][SLOTW-1:0] edge_mem_r [NUM_STATES];
  logic [EDGES_PER_STATE-1:0][SLOTW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    for (int s = 0; s < EDGES_PER_STATE; s++) begin
      if (wr_en && wr_slot_en[s]) begin
        edge_mem_r[wr_row][s] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= edge_mem_r[rd_row];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/dtm_match.sv =====
// Edge search: lowest valid slot whose mask shares a bit with the class mask.
// Uses dtm_pkg for match_res_t and the state field width.
`timescale 1ns / 1ps

module dtm_match #(
  parameter int EDGES_PER_STATE = dtm_pkg::DEF_EDGES_PER_STATE,
  parameter int CLASS_BITS      = dtm_pkg::DEF_CLASS_BITS,
  localparam int SLOTW = 1 + dtm_pkg::STATE_W + CLASS_BITS
) (
  input  logic [EDGES_PER_STATE-1:0][SLOTW-1:0] row,
  input  logic [CLASS_BITS-1:0]                 cls,
  input  logic                                  in_range,
  output dtm_pkg::match_res_t                   res
);

  // slot layout: {valid, target, mask}
  always_comb begin
    res = '0;
    for (int s = EDGES_PER_STATE - 1; s >= 0; s--) begin
      if (row[s][SLOTW-1] && (|(row[s][CLASS_BITS-1:0] & cls))) begin
        res.hit    = in_range;
        res.target = row[s][CLASS_BITS +: dtm_pkg::STATE_W];
      end
    end
  end

endmodule

// ===== tb/sv/dfa_token_matcher_tb.sv =====
// Self-checking bench for dfa_token_matcher: directed walks through a small
// hand-built automaton, then randomly built automata fed with random tokens.
// Depends on dtm_pkg and the matcher RTL in src; reads no files.
`timescale 1ns / 1ps

module dfa_token_matcher_tb;
  import dtm_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  // This covers any request that gives no result but may still be in flight
  // inside the block when the queue empties.
  localparam int DRAIN_CYCLES = 8;

  // One request on the input channel, every field present whatever the kind.
  typedef struct {
    item_kind_t             kind;
    logic [CHAR_W-1:0]      ch;
    logic                   last;
    logic [STATE_W-1:0]     state_index;
    logic [2:0]             slot_index;
    logic [STATE_W-1:0]     target_state;
    logic [MASK_IN_W-1:0]   edge_mask;
    logic                   slot_valid;
    logic [MASK_IN_W-1:0]   class_mask;
  } request_t;

  // What a finished (or abandoned) token reports.
  typedef struct packed {
    logic               accepted;
    logic               at_end_state;
    logic [STATE_W-1:0] final_state;
  } verdict_t;

  // All block inputs start at known values.
  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic [1:0]            in_kind         = '0;
  logic [CHAR_W-1:0]     in_ch           = '0;
  logic                  in_last         = 1'b0;
  logic [STATE_W-1:0]    in_state_index  = '0;
  logic [2:0]            in_slot_index   = '0;
  logic [STATE_W-1:0]    in_target_state = '0;
  logic [MASK_IN_W-1:0]  in_edge_mask    = '0;
  logic                  in_slot_valid   = 1'b0;
  logic [MASK_IN_W-1:0]  in_class_mask   = '0;
  logic                  out_stall       = 1'b0;
  logic                  cfg_psel        = 1'b0;
  logic                  cfg_penable     = 1'b0;
  logic                  cfg_pwrite      = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr       = '0;
  logic [CFG_DW-1:0]     cfg_pwdata      = '0;

  logic                  in_stall;
  logic                  out_valid;
  logic                  out_accepted;
  logic                  out_at_end_state;
  logic [STATE_W-1:0]    out_final_state;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  dfa_token_matcher dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_ch            (in_ch),
    .in_last          (in_last),
    .in_state_index   (in_state_index),
    .in_slot_index    (in_slot_index),
    .in_target_state  (in_target_state),
    .in_edge_mask     (in_edge_mask),
    .in_slot_valid    (in_slot_valid),
    .in_class_mask    (in_class_mask),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_at_end_state (out_at_end_state),
    .out_final_state  (out_final_state),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow of the matcher: registers, token walk and both tables.
  // ---------------------------------------------------------------------
  bit [STATE_W-1:0]   start_reg;
  bit [STATE_W-1:0]   end_reg;
  bit [STATE_W-1:0]   walk_state;
  bit                 walk_dead;     // token already stuck, rest is skipped
  bit                 slot_on   [DEF_NUM_STATES][DEF_EDGES_PER_STATE];
  bit [STATE_W-1:0]   slot_to   [DEF_NUM_STATES][DEF_EDGES_PER_STATE];
  bit [MASK_IN_W-1:0] slot_bits [DEF_NUM_STATES][DEF_EDGES_PER_STATE];
  bit [MASK_IN_W-1:0] byte_class [CLASS_ENTRIES];

  verdict_t expected_verdicts [$];

  int  error_count   = 0;
  int  cycle_count   = 0;
  int  requests_sent = 0;
  bit  idle_on       = 1'b1;   // random gaps and stalls allowed
  int  stall_hold    = 0;
  verdict_t want;

  // Class bit positions used by the current random automaton.
  logic [4:0] class_pos [6];

  // Apply one accepted request to the shadow; queue a verdict when the token
  // closes (last character or empty token).
  function automatic void track_request(request_t r);
    verdict_t v;
    bit       hit;
    int       s;
    case (r.kind)
      KIND_CHAR: begin
        if (!walk_dead) begin
          hit = 1'b0;
          // lowest enabled slot sharing a class bit wins
          for (s = 0; s < DEF_EDGES_PER_STATE; s++) begin
            if (!hit && slot_on[walk_state][s] &&
                (slot_bits[walk_state][s] & byte_class[r.ch]) != 0) begin
              hit        = 1'b1;
              walk_state = slot_to[walk_state][s];
            end
          end
          walk_dead = !hit;
        end
        if (r.last) begin
          v.accepted     = !walk_dead;
          v.at_end_state = !walk_dead && (walk_state == end_reg);
          v.final_state  = walk_state;
          expected_verdicts = {expected_verdicts, v};
          walk_state = start_reg;
          walk_dead  = 1'b0;
        end
      end
      KIND_EDGE_WR: begin
        slot_on  [r.state_index][r.slot_index] = r.slot_valid;
        slot_to  [r.state_index][r.slot_index] = r.target_state;
        slot_bits[r.state_index][r.slot_index] = r.edge_mask;
      end
      KIND_CLASS_WR: byte_class[r.ch] = r.class_mask;
      default: begin
        // empty token: always rejected, reports start, abandons any token
        v.accepted     = 1'b0;
        v.at_end_state = 1'b0;
        v.final_state  = start_reg;
        expected_verdicts = {expected_verdicts, v};
        walk_state = start_reg;
        walk_dead  = 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Request channel driver. Called at a rising edge; returns at the edge
  // where the request was taken, with in_valid still high so a following
  // request can go out back to back.
  // ---------------------------------------------------------------------
  task automatic send_request(input request_t r);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= r.kind;
    in_ch           <= r.ch;
    in_last         <= r.last;
    in_state_index  <= r.state_index;
    in_slot_index   <= r.slot_index;
    in_target_state <= r.target_state;
    in_edge_mask    <= r.edge_mask;
    in_slot_valid   <= r.slot_valid;
    in_class_mask   <= r.class_mask;
    do @(posedge clk); while (in_stall !== 1'b0);
    track_request(r);
    requests_sent++;
  endtask

  // Fields a request's kind does not use still carry random values.
  function automatic request_t noise_request();
    request_t r;
    r.kind         = item_kind_t'($urandom_range(0, 3));
    r.ch           = 8'($urandom_range(0, 255));
    r.last         = 1'($urandom_range(0, 1));
    r.state_index  = STATE_W'($urandom_range(0, DEF_NUM_STATES - 1));
    r.slot_index   = 3'($urandom_range(0, DEF_EDGES_PER_STATE - 1));
    r.target_state = STATE_W'($urandom_range(0, DEF_NUM_STATES - 1));
    r.edge_mask    = $urandom;
    r.slot_valid   = 1'($urandom_range(0, 1));
    r.class_mask   = $urandom;
    return r;
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
    request_t r;
    r      = noise_request();
    r.kind = KIND_CHAR;
    r.ch   = ch;
    r.last = last;
    send_request(r);
  endtask

  task automatic send_slot(input logic [STATE_W-1:0] st, input logic [2:0] sl,
                           input logic [STATE_W-1:0] tgt,
                           input logic [MASK_IN_W-1:0] mask, input logic on);
    request_t r;
    r              = noise_request();
    r.kind         = KIND_EDGE_WR;
    r.state_index  = st;
    r.slot_index   = sl;
    r.target_state = tgt;
    r.edge_mask    = mask;
    r.slot_valid   = on;
    send_request(r);
  endtask

  task automatic send_class(input logic [CHAR_W-1:0] ch,
                            input logic [MASK_IN_W-1:0] mask);
    request_t r;
    r            = noise_request();
    r.kind       = KIND_CLASS_WR;
    r.ch         = ch;
    r.class_mask = mask;
    send_request(r);
  endtask

  task automatic send_empty();
    request_t r;
    r      = noise_request();
    r.kind = KIND_EMPTY;
    send_request(r);
  endtask

  // Park the request channel, let every verdict come back, then give any
  // table write still in flight time to land. Register writes follow this.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Register port: setup cycle then access cycle. Upper data bits carry
  // noise; only the state width is kept.
  // ---------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_AW-1:0] addr,
                           input logic [STATE_W-1:0] value);
    logic [CFG_DW-1:0] data;
    data          = $urandom;
    data[STATE_W-1:0] = value;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if (addr == REG_START_ADDR) begin
      // a new start register also restarts the token walk
      start_reg  = value;
      walk_state = value;
      walk_dead  = 1'b0;
    end else if (addr == REG_END_ADDR) begin
      end_reg = value;
    end
  endtask

  task automatic check_reg(input logic [CFG_AW-1:0] addr);
    logic [STATE_W-1:0] exp_val;
    exp_val = (addr == REG_START_ADDR) ? start_reg : end_reg;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata[STATE_W-1:0] !== exp_val) begin
      $error("register @%0d readback: expected %0d, got %0d",
             addr, exp_val, cfg_prdata[STATE_W-1:0]);
      error_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Mask over the current class positions, now and then a raw pattern.
  function automatic logic [MASK_IN_W-1:0] pick_mask();
    logic [MASK_IN_W-1:0] m;
    if ($urandom_range(0, 7) == 0) return $urandom;
    m = 32'h1 << class_pos[$urandom_range(0, 5)];
    if ($urandom_range(0, 1) == 1) m |= 32'h1 << class_pos[$urandom_range(0, 5)];
    return m;
  endfunction

  // ---------------------------------------------------------------------
  // Directed tests. Start and end are both 0 after reset.
  // ---------------------------------------------------------------------

  // Tables are clear: an empty token, and a byte whose class is zero.
  task automatic test_empty_and_unmapped();
    send_empty();
    send_char(8'h00, 1'b1);
  endtask

  // Small automaton: 0 --FF--> 63 --00--> 0. A disabled slot 0 with every
  // class bit must be skipped; a later enabled slot 3 must beat slot 7.
  task automatic test_slot_priority();
    send_class(8'hFF, 32'h8000_0000);
    send_class(8'h00, 32'h0000_0001);
    send_slot(6'd0, 3'd7, 6'd63, 32'h8000_0000, 1'b1);
    send_slot(6'd0, 3'd0, 6'd5, 32'hFFFF_FFFF, 1'b0);
    send_slot(6'd63, 3'd0, 6'd0, 32'h0000_0001, 1'b1);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);      // back at 0 = end_state
    send_slot(6'd0, 3'd3, 6'd10, 32'h8000_0000, 1'b1);
    send_char(8'hFF, 1'b1);      // slot 3 wins, lands on 10
  endtask

  // State 10 has no slots: the token sticks there and later characters
  // are skipped up to the last one.
  task automatic test_stuck_token();
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  // An empty token drops a half-fed token; table writes act mid-token.
  task automatic test_midtoken_changes();
    send_char(8'hFF, 1'b0);
    send_empty();
    send_char(8'hFF, 1'b0);
    send_slot(6'd10, 3'd0, 6'd33, 32'h0000_0001, 1'b1);
    send_char(8'h00, 1'b1);      // 10 -> 33 through the fresh slot
    send_slot(6'd0, 3'd3, 6'd10, 32'h8000_0000, 1'b0);
    send_char(8'hFF, 1'b1);      // slot 3 removed, slot 7 to 63
  endtask

  // Register reset values, end state at the top extreme, and a start write
  // that aborts a token in progress.
  task automatic test_registers();
    drain_results();
    check_reg(REG_START_ADDR);
    check_reg(REG_END_ADDR);
    write_reg(REG_END_ADDR, 6'd63);
    send_char(8'hFF, 1'b1);      // lands on 63, flagged as end state
    send_char(8'hFF, 1'b0);      // token left open
    drain_results();
    write_reg(REG_START_ADDR, 6'd63);
    send_char(8'h00, 1'b1);      // walk restarted at 63, goes to 0
    send_empty();                // reports the new start
    drain_results();
    check_reg(REG_START_ADDR);
    check_reg(REG_END_ADDR);
  endtask

  // ---------------------------------------------------------------------
  // Random automata. Each phase picks start/end, a handful of class bits
  // and working states, loads class entries and slots over them, then
  // sends tokens mostly built from loaded bytes so walks go deep. Noise:
  // raw table writes, unloaded bytes, empty tokens cutting tokens short.
  // The last phase runs with no gaps and no stalls.
  // ---------------------------------------------------------------------
  task automatic test_random_tokens();
    logic [STATE_W-1:0] live [6];
    logic [CHAR_W-1:0]  pool [$];
    logic [STATE_W-1:0] next_start;
    logic [STATE_W-1:0] next_end;
    logic [CHAR_W-1:0]  c;
    int p, i, k, j, len, mark;
    for (p = 0; p < 5; p++) begin
      drain_results();
      idle_on = (p != 4);
      case (p)
        0: begin
          next_start = '0;
          next_end   = '1;
        end
        1: begin
          next_start = '1;
          next_end   = '0;
        end
        default: begin
          next_start = STATE_W'($urandom_range(0, DEF_NUM_STATES - 1));
          next_end   = STATE_W'($urandom_range(0, DEF_NUM_STATES - 1));
        end
      endcase
      write_reg(REG_START_ADDR, next_start);
      write_reg(REG_END_ADDR, next_end);

      for (i = 0; i < 6; i++) class_pos[i] = 5'($urandom_range(0, MASK_IN_W - 1));
      live[0] = start_reg;
      live[1] = end_reg;
      for (i = 2; i < 6; i++) live[i] = STATE_W'($urandom_range(0, DEF_NUM_STATES - 1));

      pool.delete();
      for (i = 0; i < 24; i++) begin
        c = 8'($urandom_range(0, 255));
        pool = {pool, c};
        send_class(c, pick_mask());
      end
      for (i = 0; i < 6; i++) begin
        for (k = 0; k < 3; k++) begin
          send_slot(live[i], 3'($urandom_range(0, DEF_EDGES_PER_STATE - 1)),
                    live[$urandom_range(0, 5)], pick_mask(),
                    $urandom_range(0, 7) != 0);
        end
      end

      mark = requests_sent;
      while (requests_sent - mark < 72) begin
        case ($urandom_range(0, 19))
          0: send_empty();
          1: send_slot(STATE_W'($urandom_range(0, DEF_NUM_STATES - 1)),
                       3'($urandom_range(0, DEF_EDGES_PER_STATE - 1)),
                       STATE_W'($urandom_range(0, DEF_NUM_STATES - 1)), $urandom,
                       1'($urandom_range(0, 1)));
          2: send_class(8'($urandom_range(0, 255)), $urandom);
          default: begin
            len = $urandom_range(1, 6);
            for (j = 0; j < len; j++) begin
              if ($urandom_range(0, 15) == 0)
                send_class(pool[$urandom_range(0, pool.size() - 1)], pick_mask());
              c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                              : pool[$urandom_range(0, pool.size() - 1)];
              if (j == len - 1 && $urandom_range(0, 19) == 0) send_empty();
              else send_char(c, j == len - 1);
            end
          end
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stall bursts while idling is on.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_hold <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Every result taken is matched against the oldest queued verdict.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_verdicts.size() == 0) begin
        $error("result with nothing expected: accepted %0b final_state %0d",
               out_accepted, out_final_state);
        error_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_accepted !== want.accepted) begin
          $error("accepted: expected %0b, got %0b", want.accepted, out_accepted);
          error_count++;
        end
        if (out_at_end_state !== want.at_end_state) begin
          $error("at_end_state: expected %0b, got %0b",
                 want.at_end_state, out_at_end_state);
          error_count++;
        end
        if (out_final_state !== want.final_state) begin
          $error("final_state: expected %0d, got %0d",
                 want.final_state, out_final_state);
          error_count++;
        end
      end
    end
  end

  // Watchdog on total run length (clearing pass included).
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("dfa_token_matcher_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_and_unmapped();
    test_slot_priority();
    test_stuck_token();
    test_midtoken_changes();
    test_registers();
    test_random_tokens();
    drain_results();
    if (error_count == 0) begin
      $display("dfa_token_matcher_tb OK");
    end else begin
      $display("dfa_token_matcher_tb NOT OK");
    end
    $finish;
  end

endmodule
